@@ hdl/v2c_pkg.sv @@
// Package: shared constants and types for the 2D convolution unit.
`timescale 1ns / 1ps
package v2c_pkg;
    localparam int MaxKernelDim = 8;
    localparam int MaxImageCols = 1024;

    // Register indexes on the configuration port.
    localparam logic [1:0] RegImageRows  = 2'd0;
    localparam logic [1:0] RegImageCols  = 2'd1;
    localparam logic [1:0] RegKernelRows = 2'd2;
    localparam logic [1:0] RegKernelCols = 2'd3;

    // Input operation codes.
    localparam logic OpKernel = 1'b0;
    localparam logic OpImage  = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic kload;     // write kernel coefficient
        logic pwrite;    // write pixel into line store, advance counters
        logic mac_start; // clear accumulator, arm first read
        logic mac_step;  // issue next tap read
        logic out_load;  // capture result into output register
        logic restart;   // clear kernel and image counters
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic win_ok;    // pixel completes a window
        logic tap_last;  // last tap address issued
    } t_stat;
endpackage

@@ hdl/v2c_if.sv @@
// Interfaces: valid/ready item channels.
`timescale 1ns / 1ps
interface v2c_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] value;
    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface v2c_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic [15:0] out_row;
    logic [9:0]  out_col;
    logic        last;
    modport source (output valid, output result, output out_row, output out_col,
                    output last, input ready);
    modport sink   (input valid, input result, input out_row, input out_col,
                    input last, output ready);
endinterface

@@ hdl/v2c_ctrl.sv @@
// Controller: sequences kernel loads, pixel writes and the tap walk.
`timescale 1ns / 1ps
module v2c_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_op,
    input  logic               i_cfg_wr,
    input  logic               i_out_busy,
    input  v2c_pkg::t_stat     i_stat,
    output logic               o_in_ready,
    output v2c_pkg::t_cmd      o_cmd
);
    localparam logic [2:0] StIdle   = 3'd0;
    localparam logic [2:0] StMac    = 3'd1;
    localparam logic [2:0] StDrain  = 3'd2;
    localparam logic [2:0] StDrain2 = 3'd3;
    localparam logic [2:0] StDone   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       w_acc;

    assign o_in_ready = (r_state == StIdle);
    assign w_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.restart = i_cfg_wr;
        unique case (r_state)
            StIdle: begin
                if (w_acc && i_in_op == v2c_pkg::OpKernel) begin
                    o_cmd.kload = 1'b1;
                end else if (w_acc) begin
                    o_cmd.pwrite = 1'b1;
                    if (i_stat.win_ok) begin
                        o_cmd.mac_start = 1'b1;
                        n_state = StMac;
                    end
                end
            end
            StMac: begin
                o_cmd.mac_step = 1'b1;
                if (i_stat.tap_last) n_state = StDrain;
            end
            // wait out the read and product stages of the last tap
            StDrain: n_state = StDrain2;
            StDrain2: n_state = StDone;
            StDone: begin
                if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= StIdle;
        else          r_state <= n_state;
    end
endmodule

@@ hdl/v2c_dp.sv @@
// Datapath: kernel store, line store, counters and the shared MAC.
`timescale 1ns / 1ps
module v2c_dp #(
    parameter int MAX_KERNEL_DIM = v2c_pkg::MaxKernelDim,
    parameter int MAX_IMAGE_COLS = v2c_pkg::MaxImageCols
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  v2c_pkg::t_cmd      i_cmd,
    input  logic [31:0]        i_value,
    input  logic [15:0]        i_image_rows,
    input  logic [10:0]        i_image_cols,
    input  logic [3:0]         i_kernel_rows,
    input  logic [3:0]         i_kernel_cols,
    input  logic               i_out_ready,
    output v2c_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output logic [31:0]        o_result,
    output logic [15:0]        o_out_row,
    output logic [9:0]         o_out_col,
    output logic               o_last
);
    localparam int KdW  = $clog2(MAX_KERNEL_DIM + 1);
    localparam int KiW  = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;
    localparam int KsW  = $clog2(MAX_KERNEL_DIM * MAX_KERNEL_DIM + 1);
    localparam int KaW  = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM * MAX_KERNEL_DIM) : 1;
    localparam int CW   = $clog2(MAX_IMAGE_COLS + 1);
    localparam int CiW  = $clog2(MAX_IMAGE_COLS);
    localparam int LaW  = KiW + CiW;

    logic [31:0] r_kmem [MAX_KERNEL_DIM * MAX_KERNEL_DIM];
    // ring of 2**KiW rows, each 2**CiW wide
    logic [31:0] r_lmem [2**LaW];

    // Clamp configuration.
    logic [15:0]    w_rows;
    logic [CW-1:0]  w_cols;
    logic [KdW-1:0] w_kr, w_kc;
    logic [KsW-1:0] w_ksize;
    always_comb begin
        w_rows = (i_image_rows == 16'd0) ? 16'd1 : i_image_rows;
        if (i_image_cols == 11'd0) w_cols = CW'(1);
        else if ({21'd0, i_image_cols} > 32'(MAX_IMAGE_COLS)) w_cols = CW'(MAX_IMAGE_COLS);
        else w_cols = CW'(i_image_cols);
        if (i_kernel_rows == 4'd0) w_kr = KdW'(1);
        else if ({28'd0, i_kernel_rows} > 32'(MAX_KERNEL_DIM)) w_kr = KdW'(MAX_KERNEL_DIM);
        else w_kr = KdW'(i_kernel_rows);
        if (i_kernel_cols == 4'd0) w_kc = KdW'(1);
        else if ({28'd0, i_kernel_cols} > 32'(MAX_KERNEL_DIM)) w_kc = KdW'(MAX_KERNEL_DIM);
        else w_kc = KdW'(i_kernel_cols);
        w_ksize = KsW'(w_kr * w_kc);
    end

    // Kernel load: stored flipped.
    logic [KsW-1:0] r_kcnt, w_kcnt0;
    assign w_kcnt0 = (r_kcnt >= w_ksize) ? '0 : r_kcnt;
    always_ff @(posedge i_clk) begin
        if (i_cmd.kload) r_kmem[KaW'(w_ksize - 1'b1 - w_kcnt0)] <= i_value;
    end

    // Image counters.
    logic [15:0]   r_row, w_row;
    logic [CW-1:0] r_col, w_col;
    logic          w_wrap;
    assign w_wrap = (r_row >= w_rows) || (r_col >= w_cols);
    assign w_row  = w_wrap ? '0 : r_row;
    assign w_col  = w_wrap ? '0 : r_col;
    assign o_stat.win_ok = ({16'd0, w_row} + 32'd1 >= 32'(w_kr)) &&
                           (32'(w_col) + 32'd1 >= 32'(w_kc));

    always_ff @(posedge i_clk) begin
        if (i_cmd.pwrite) r_lmem[{w_row[KiW-1:0], w_col[CiW-1:0]}] <= i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_kcnt <= '0;
            r_row  <= '0;
            r_col  <= '0;
        end else begin
            if (i_cmd.kload) begin
                r_kcnt <= (w_kcnt0 + 1'b1 >= w_ksize) ? '0 : w_kcnt0 + 1'b1;
            end
            if (i_cmd.pwrite) begin
                if (w_col + 1'b1 >= w_cols) begin
                    r_col <= '0;
                    r_row <= (w_row + 16'd1 >= w_rows) ? '0 : w_row + 16'd1;
                end else begin
                    r_col <= w_col + 1'b1;
                    r_row <= w_row;
                end
            end
        end
    end

    // Tap walk: address stage, registered reads, product, accumulate.
    logic [15:0]    r_orow;
    logic [CiW-1:0] r_ocol;
    logic           r_olast;
    logic [KiW-1:0] r_tk, r_tl;
    logic [KiW-1:0] r_lrow;
    logic [31:0]    r_kd, r_ld, r_prod, r_acc;
    logic           r_v1, r_v2;
    logic           w_tlast;

    assign w_tlast = ({1'b0, r_tk} + 1'b1 == w_kr) && ({1'b0, r_tl} + 1'b1 == w_kc);
    assign o_stat.tap_last = w_tlast;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_start) begin
            r_orow  <= w_row + 16'd1 - 16'(w_kr);
            r_ocol  <= CiW'(w_col + 1'b1 - CW'(w_kc));
            r_olast <= (w_row + 16'd1 == w_rows) && (w_col + 1'b1 == w_cols);
            r_tk    <= '0;
            r_tl    <= '0;
            r_lrow  <= KiW'(w_row + 16'd1 - 16'(w_kr));
        end else if (i_cmd.mac_step) begin
            if ({1'b0, r_tl} + 1'b1 == w_kc) begin
                r_tl   <= '0;
                r_tk   <= r_tk + 1'b1;
                r_lrow <= r_lrow + 1'b1;
            end else begin
                r_tl <= r_tl + 1'b1;
            end
        end
        if (i_cmd.mac_step) begin
            r_kd <= r_kmem[KaW'(r_tk * w_kc + r_tl)];
            r_ld <= r_lmem[{r_lrow, CiW'(r_ocol + r_tl)}];
        end
        r_prod <= r_kd * r_ld;
        if (i_cmd.mac_start) r_acc <= '0;
        else if (r_v2)       r_acc <= r_acc + r_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_step;
            r_v2 <= r_v1;
        end
    end

    // Output register.
    logic r_ovalid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (i_cmd.out_load) r_ovalid <= 1'b1;
        else if (i_out_ready) r_ovalid <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_result  <= r_acc;
            o_out_row <= r_orow;
            o_out_col <= 10'(r_ocol);
            o_last    <= r_olast;
        end
    end
    assign o_out_valid = r_ovalid;
endmodule

@@ hdl/valid_2d_convolution_unit.sv @@
// Top level: valid-mode 2D integer convolution unit.
`timescale 1ns / 1ps
// Load kernel_rows*kernel_cols coefficients (operation 0, row-major), then stream
// image elements (operation 1, raster order). Each element that completes a window
// yields one result after a walk of kernel_rows*kernel_cols taps through one shared
// multiply-accumulate, and input is not taken again until that result is loaded
// into the output register; kernel loads and elements without a result never stall it.
// The walk is set by the single read port of each of the kernel and line memories.
// The output register lets the next item start while a result waits. Any register
// write restarts the kernel load and the image.
module valid_2d_convolution_unit #(
    parameter int MAX_KERNEL_DIM = v2c_pkg::MaxKernelDim,
    parameter int MAX_IMAGE_COLS = v2c_pkg::MaxImageCols
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    v2c_in_if.sink      in_ch,
    v2c_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] r_image_rows;
    logic [10:0] r_image_cols;
    logic [3:0]  r_kernel_rows, r_kernel_cols;
    logic        w_cfg_wr, w_reg_wr;
    v2c_pkg::t_cmd  w_cmd;
    v2c_pkg::t_stat w_stat;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_reg_wr = w_cfg_wr && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_rows  <= 16'd1;
            r_image_cols  <= 11'd1;
            r_kernel_rows <= 4'd1;
            r_kernel_cols <= 4'd1;
        end else if (w_reg_wr) begin
            unique case (paddr[3:2])
                v2c_pkg::RegImageRows:  r_image_rows  <= pwdata[15:0];
                v2c_pkg::RegImageCols:  r_image_cols  <= pwdata[10:0];
                v2c_pkg::RegKernelRows: r_kernel_rows <= pwdata[3:0];
                v2c_pkg::RegKernelCols: r_kernel_cols <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            v2c_pkg::RegImageRows:  prdata = {16'd0, r_image_rows};
            v2c_pkg::RegImageCols:  prdata = {21'd0, r_image_cols};
            v2c_pkg::RegKernelRows: prdata = {28'd0, r_kernel_rows};
            v2c_pkg::RegKernelCols: prdata = {28'd0, r_kernel_cols};
            default:                prdata = '0;
        endcase
    end

    v2c_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_in_op    (in_ch.operation),
        .i_cfg_wr   (w_reg_wr),
        .i_out_busy (out_ch.valid && !out_ch.ready),
        .i_stat     (w_stat),
        .o_in_ready (in_ch.ready),
        .o_cmd      (w_cmd)
    );

    v2c_dp #(
        .MAX_KERNEL_DIM (MAX_KERNEL_DIM),
        .MAX_IMAGE_COLS (MAX_IMAGE_COLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_value       (in_ch.value),
        .i_image_rows  (r_image_rows),
        .i_image_cols  (r_image_cols),
        .i_kernel_rows (r_kernel_rows),
        .i_kernel_cols (r_kernel_cols),
        .i_out_ready   (out_ch.ready),
        .o_stat        (w_stat),
        .o_out_valid   (out_ch.valid),
        .o_result      (out_ch.result),
        .o_out_row     (out_ch.out_row),
        .o_out_col     (out_ch.out_col),
        .o_last        (out_ch.last)
    );
endmodule

@@ hdl/v2c_checker.sv @@
// Checker: port-level properties of the convolution unit, bound to the top level.
`timescale 1ns / 1ps
module v2c_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_op,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_result,
    input logic        i_pready
);
    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pready)
        else $error("pready dropped");

    // A kernel item never blocks the next one.
    a_kload_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op == v2c_pkg::OpKernel |=> i_in_ready)
        else $error("kernel load stalled input");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result after reset");
endmodule

bind valid_2d_convolution_unit v2c_checker u_v2c_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_ch.valid),
    .i_in_ready  (in_ch.ready),
    .i_in_op     (in_ch.operation),
    .i_out_valid (out_ch.valid),
    .i_out_ready (out_ch.ready),
    .i_result    (out_ch.result),
    .i_pready    (pready)
);

@@ sim/valid_2d_convolution_unit_test.sv @@
// Testbench: streamed 2D convolution checked against an inline window-sum predictor.
`timescale 1ns / 1ps
module valid_2d_convolution_unit_test;
    typedef struct packed {
        logic        op;
        logic [31:0] value;
    } t_item;

    typedef struct packed {
        logic [31:0] sum;
        logic [15:0] orow;
        logic [9:0]  ocol;
        logic        last;
    } t_conv;

    localparam int WatchLimit = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    v2c_in_if  in_ch ();
    v2c_out_if out_ch ();

    valid_2d_convolution_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [15:0] img_rows_q;
    logic [10:0] img_cols_q;
    logic [3:0]  ker_rows_q, ker_cols_q;
    logic [31:0] coeff_mem [v2c_pkg::MaxKernelDim*v2c_pkg::MaxKernelDim];
    logic [31:0] line_mem  [v2c_pkg::MaxKernelDim][v2c_pkg::MaxImageCols];
    int unsigned coeff_cnt, pix_row, pix_col;

    t_item pending_items[$];
    t_conv expected_sums[$];
    int    errors = 0;
    int    n_results = 0;
    int    idle_cycles = 0;
    bit    hold_sender = 0;
    bit    in_taken = 0;

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic void predict_item(t_item it);
        int unsigned rows, cols, kr, kc, ksize, r, c, orow, ocol;
        logic [31:0] acc;
        t_conv e;
        rows = (img_rows_q == 0) ? 1 : img_rows_q;
        cols = clamp_dim(img_cols_q, v2c_pkg::MaxImageCols);
        kr = clamp_dim(ker_rows_q, v2c_pkg::MaxKernelDim);
        kc = clamp_dim(ker_cols_q, v2c_pkg::MaxKernelDim);
        ksize = kr * kc;
        if (it.op == v2c_pkg::OpKernel) begin
            if (coeff_cnt >= ksize) coeff_cnt = 0;
            coeff_mem[ksize - 1 - coeff_cnt] = it.value;
            coeff_cnt++;
            if (coeff_cnt >= ksize) coeff_cnt = 0;
            return;
        end
        if (pix_row >= rows || pix_col >= cols) begin
            pix_row = 0;
            pix_col = 0;
        end
        r = pix_row;
        c = pix_col;
        line_mem[r % v2c_pkg::MaxKernelDim][c] = it.value;
        if (r + 1 >= kr && c + 1 >= kc) begin
            orow = r + 1 - kr;
            ocol = c + 1 - kc;
            acc = '0;
            for (int k = 0; k < kr; k++)
                for (int l = 0; l < kc; l++)
                    acc += line_mem[(orow + k) % v2c_pkg::MaxKernelDim][ocol + l]
                           * coeff_mem[k * kc + l];
            e.sum = acc;
            e.orow = orow[15:0];
            e.ocol = ocol[9:0];
            e.last = (r + 1 == rows && c + 1 == cols);
            expected_sums.push_back(e);
        end
        c++;
        if (c >= cols) begin
            c = 0;
            r++;
            if (r >= rows) r = 0;
        end
        pix_row = r;
        pix_col = c;
    endfunction

    // sample accepted input items at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predict_item({in_ch.operation, in_ch.value});
            in_taken = 1'b1;
        end
    end

    // driver: bursts with random gaps
    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_taken = 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            in_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0 && !hold_sender) begin
                t_item it;
                it = pending_items.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.operation <= it.op;
                in_ch.value     <= it.value;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stalls on a rotating pattern, at random, or not at all, switching modes at random
    logic [15:0] stall_pat = 16'b1011_0000_1110_0000;
    int stall_mode = 0;
    always @(negedge i_clk) begin
        stall_pat <= {stall_pat[14:0], stall_pat[15]};
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= stall_pat[0];
            default: out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            t_conv got, want;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.result, out_ch.out_row, out_ch.out_col, out_ch.last};
                n_results <= n_results + 1;
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    errors++;
                end else begin
                    want = expected_sums.pop_front();
                    if (got.sum !== want.sum) begin
                        $display("%0t: result expected %h actual %h", $time, want.sum, got.sum);
                        errors++;
                    end
                    if (got.orow !== want.orow) begin
                        $display("%0t: out_row expected %0d actual %0d", $time, want.orow,
                                 got.orow);
                        errors++;
                    end
                    if (got.ocol !== want.ocol) begin
                        $display("%0t: out_col expected %0d actual %0d", $time, want.ocol,
                                 got.ocol);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (idle_cycles >= WatchLimit) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_sums.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            v2c_pkg::RegImageRows:  img_rows_q = data[15:0];
            v2c_pkg::RegImageCols:  img_cols_q = data[10:0];
            v2c_pkg::RegKernelRows: ker_rows_q = data[3:0];
            default:                ker_cols_q = data[3:0];
        endcase
        coeff_cnt = 0; pix_row = 0; pix_col = 0;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // drain both queues, then let any result-free pipeline work settle
    task automatic settle();
        wait (pending_items.size() == 0);
        @(negedge i_clk);
        while (in_ch.valid || expected_sums.size() > 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic set_shape(int rows, int cols, int kr, int kc);
        settle();
        apb_write(v2c_pkg::RegImageRows, rows);
        apb_write(v2c_pkg::RegImageCols, cols);
        apb_write(v2c_pkg::RegKernelRows, kr);
        apb_write(v2c_pkg::RegKernelCols, kc);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_kernel(int n);
        for (int i = 0; i < n; i++)
            pending_items.push_back({v2c_pkg::OpKernel, rand_word()});
    endtask

    task automatic queue_pixels(int n);
        for (int i = 0; i < n; i++)
            pending_items.push_back({v2c_pkg::OpImage, rand_word()});
    endtask

    int unsigned sr, sc, skr, skc, kfill;
    int images_done = 0;
    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0; in_ch.operation = v2c_pkg::OpKernel; in_ch.value = '0;
        out_ch.ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        img_rows_q = 1; img_cols_q = 1; ker_rows_q = 1; ker_cols_q = 1;
        coeff_cnt = 0; pix_row = 0; pix_col = 0;
        foreach (coeff_mem[i]) coeff_mem[i] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset shape 1x1 with 1x1 kernel, extremes of the value field
        pending_items.push_back({v2c_pkg::OpKernel, 32'h7FFF_FFFF});
        pending_items.push_back({v2c_pkg::OpImage, 32'h8000_0000});
        pending_items.push_back({v2c_pkg::OpImage, 32'hFFFF_FFFF});
        pending_items.push_back({v2c_pkg::OpKernel, 32'h8000_0000});
        pending_items.push_back({v2c_pkg::OpImage, 32'h7FFF_FFFF});
        // out-of-range registers (zeros, oversized), extra coefficients
        set_shape(0, 0, 0, 0);
        queue_kernel(3); queue_pixels(3);
        set_shape(3, 2000, 15, 2);
        queue_kernel(17); queue_pixels(4);
        // kernel larger than image: no output
        set_shape(2, 3, 3, 4);
        queue_kernel(12); queue_pixels(6);
        // sender pause until every result has come
        set_shape(9, 9, 8, 8);
        queue_kernel(64); queue_pixels(81);
        while (pending_items.size() > 2) @(negedge i_clk);
        hold_sender = 1;
        @(negedge i_clk);
        while (in_ch.valid || expected_sums.size() > 0) @(negedge i_clk);
        hold_sender = 0;
        settle();
        // widest row in full, then the first elements of the deepest image
        set_shape(1, 1024, 1, 8);
        queue_kernel(8); queue_pixels(1024);
        set_shape(65535, 8, 1, 8);
        queue_kernel(8); queue_pixels(30);

        // random images, mostly small, kernel reloaded mid-image now and then
        while (images_done < 5) begin
            sr = $urandom_range(1, 6); sc = $urandom_range(1, 6);
            skr = $urandom_range(1, 4); skc = $urandom_range(1, 4);
            if ($urandom_range(0, 7) == 0) begin
                skr = $urandom_range(1, 8); skc = $urandom_range(1, 8);
            end
            set_shape(sr, sc, skr, skc);
            queue_kernel(skr * skc);
            kfill = $urandom_range(0, sr * sc);
            queue_pixels(kfill);
            if ($urandom_range(0, 3) == 0) queue_kernel(skr * skc);
            queue_pixels(sr * sc - kfill + $urandom_range(0, 4));
            images_done++;
        end
        settle();
        $display("Covered %0d results over directed shapes and %0d random images,",
                 n_results, images_done);
        $display("including oversized registers, extra coefficients and mid-image reloads.");
        if (errors == 0 && expected_sums.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
